FILE: rtl/aligned_per_integer_encoder_defines.svh
// Assertion macros for the aligned PER integer encoder.
// Used by the top level only; no other dependencies.
`ifndef ALIGNED_PER_INTEGER_ENCODER_DEFINES_SVH
`define ALIGNED_PER_INTEGER_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define APIE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("apie: same-cycle check failed");
`define APIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("apie: next-cycle check failed");
`else
`define APIE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define APIE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/apie_pkg.sv
// Shared types, constants and helper functions of the aligned PER integer encoder.
// No dependencies.
package apie_pkg;

  localparam logic ACT_CONSTRAINED   = 1'b0;
  localparam logic ACT_UNCONSTRAINED = 1'b1;

  localparam int unsigned MaxOctets = 9;
  localparam int unsigned FrameW    = 8 * MaxOctets;

  // Differences stage result.
  typedef struct packed {
    logic        action;
    logic        bad;
    logic [63:0] value;
    logic [63:0] span;
    logic [63:0] offset;
  } apie_diff_t;

  // Formatted octets, first octet in the top byte.
  typedef struct packed {
    logic              bad;
    logic [3:0]        cnt;
    logic [FrameW-1:0] octets;
  } apie_frame_t;

endpackage

FILE: rtl/apie_if.sv
// Valid/ready channel interfaces of the aligned PER integer encoder.
// Depends on nothing; payload widths are fixed by the encoding format.
interface apie_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [63:0] value;
  logic signed [63:0] lower_bound;
  logic signed [63:0] upper_bound;

  modport source (output valid, action, value, lower_bound, upper_bound, input ready);
  modport sink   (input valid, action, value, lower_bound, upper_bound, output ready);
endinterface

interface apie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       bad_range;

  modport source (output valid, out_byte, last, bad_range, input ready);
  modport sink   (input valid, out_byte, last, bad_range, output ready);
endinterface

FILE: rtl/aligned_per_integer_encoder.sv
// Top level of the aligned PER integer encoder: difference stage, format stage, serializer.
// Depends on apie_pkg, apie_if.sv, apie_diff, apie_form, apie_ser and the defines header.
//
// Encodes one 64-bit integer per input transaction into octet-aligned PER octets, most
// significant first, one output transaction per octet. action 0 encodes value - lower_bound
// in the form chosen by the range size (nothing for a single-value range, one left-justified
// octet up to 256 values, two octets up to 65536, otherwise an indicator octet plus one to
// four octets of the offset's low bytes); action 1 emits a count octet and then 1, 2, 3, 4
// or 8 two's-complement octets. Under action 0, reversed bounds give one octet of zero
// with bad_range set. An input transaction passes the difference and format registers
// before the serializer loads it, and only then is its first octet offered at the output.
// The serializer sends one octet per cycle while the output is ready, as many as the item's
// octet count; an item with no octets is loaded and dropped and leaves a gap at the output.
// Input is taken in every cycle the pipeline has room, and the serializer loads the next
// item in the cycle its last octet is taken, so the output runs without gaps while items
// that carry octets are queued.
`include "aligned_per_integer_encoder_defines.svh"

module aligned_per_integer_encoder
  import apie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  apie_in_if.sink    in_i,
  apie_out_if.source out_o
);

  logic        diff_valid;
  logic        diff_ready;
  apie_diff_t  diff_data;
  logic        form_valid;
  logic        form_ready;
  apie_frame_t form_data;

  // Subtract bounds and compare their order.
  apie_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (diff_valid),
    .data_o  (diff_data),
    .ready_i (diff_ready)
  );

  // Pick the form and lay out the octets.
  apie_form u_form (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .data_i  (diff_data),
    .ready_o (diff_ready),
    .valid_o (form_valid),
    .data_o  (form_data),
    .ready_i (form_ready)
  );

  // Send octets one per transaction.
  apie_ser u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (form_valid),
    .data_i  (form_data),
    .ready_o (form_ready),
    .out_o   (out_o)
  );

  // A flagged range is always a single zero octet.
  `APIE_ASSERT_IMPLY(a_bad_single, clk_i, rst_ni, out_o.valid && out_o.bad_range,
                     out_o.last && out_o.out_byte == 8'd0)
  // The format stage never builds a flagged frame of more than one octet.
  `APIE_ASSERT_IMPLY(a_bad_len, clk_i, rst_ni, form_valid && form_data.bad,
                     form_data.cnt == 4'd1)
  // A frame held back by the serializer stays in the format stage.
  `APIE_ASSERT_NEXT(a_form_hold, clk_i, rst_ni, form_valid && !form_ready, form_valid)

endmodule

FILE: rtl/apie_diff.sv
// First pipeline stage: offset, span and bound-order check, registered.
// Depends on apie_pkg and apie_in_if.
module apie_diff
  import apie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  apie_in_if.sink     in_i,
  output logic        valid_o,
  output apie_diff_t  data_o,
  input  logic        ready_i
);

  logic       valid_q;
  apie_diff_t data_d;
  apie_diff_t data_q;

  assign in_i.ready = !valid_q || ready_i;

  always_comb begin
    data_d.action = in_i.action;
    data_d.bad    = in_i.upper_bound < in_i.lower_bound;
    data_d.value  = in_i.value;
    data_d.span   = in_i.upper_bound - in_i.lower_bound;
    data_d.offset = in_i.value - in_i.lower_bound;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/apie_form.sv
// Second pipeline stage: choose the encoding form and lay out all octets.
// Depends on apie_pkg.
module apie_form
  import apie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  apie_diff_t  data_i,
  output logic        ready_o,
  output logic        valid_o,
  output apie_frame_t data_o,
  input  logic        ready_i
);

  function automatic logic [3:0] signed_len(logic [63:0] v);
    logic [3:0] n;
    if ((&v[63:7]) || !(|v[63:7])) begin
      n = 4'd1;
    end else if ((&v[63:15]) || !(|v[63:15])) begin
      n = 4'd2;
    end else if ((&v[63:23]) || !(|v[63:23])) begin
      n = 4'd3;
    end else if ((&v[63:31]) || !(|v[63:31])) begin
      n = 4'd4;
    end else begin
      n = 4'd8;
    end
    return n;
  endfunction

  function automatic logic [3:0] unsigned_len(logic [63:0] v);
    logic [3:0] n;
    if (!(|v[63:8])) begin
      n = 4'd1;
    end else if (!(|v[63:16])) begin
      n = 4'd2;
    end else if (!(|v[63:24])) begin
      n = 4'd3;
    end else begin
      n = 4'd4;
    end
    return n;
  endfunction

  function automatic logic [3:0] bit_len(logic [7:0] v);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        b = 4'(i + 1);
      end
    end
    return b;
  endfunction

  function automatic apie_frame_t build_frame(apie_diff_t d);
    apie_frame_t f;
    logic [3:0]  n;
    logic [3:0]  gap;
    logic [3:0]  b;
    logic [7:0]  hdr;
    logic [63:0] src;
    logic [7:0]  short_oct;
    f   = '0;
    n   = 4'd1;
    hdr = 8'd0;
    src = 64'd0;
    if (d.action == ACT_UNCONSTRAINED) begin
      n   = signed_len(d.value);
      hdr = {4'd0, n};
      src = d.value;
    end else begin
      n   = unsigned_len(d.offset);
      hdr = {n[1:0] - 2'd1, 6'd0};
      src = d.offset;
    end
    gap = 4'd8 - n;
    b   = bit_len(d.span[7:0]);
    short_oct = 8'(d.offset[7:0] << (4'd8 - b));
    if (d.action == ACT_UNCONSTRAINED) begin
      f.cnt    = n + 4'd1;
      f.octets = {hdr, src << {gap[2:0], 3'b000}};
    end else if (d.bad) begin
      f.bad = 1'b1;
      f.cnt = 4'd1;
    end else if (d.span == 64'd0) begin
      f.cnt = 4'd0;
    end else if (!(|d.span[63:8])) begin
      f.cnt    = 4'd1;
      f.octets = {short_oct, 64'd0};
    end else if (!(|d.span[63:16])) begin
      f.cnt    = 4'd2;
      f.octets = {d.offset[15:0], 56'd0};
    end else begin
      f.cnt    = n + 4'd1;
      f.octets = {hdr, src << {gap[2:0], 3'b000}};
    end
    return f;
  endfunction

  logic        valid_q;
  apie_frame_t data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= build_frame(data_i);
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/apie_ser.sv
// Output stage: shift out one octet per transaction from a registered frame.
// Depends on apie_pkg and apie_out_if.
module apie_ser
  import apie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  apie_frame_t data_i,
  output logic        ready_o,
  apie_out_if.source  out_o
);

  logic              busy_q, busy_d;
  logic [3:0]        rem_q, rem_d;
  logic              bad_q, bad_d;
  logic [FrameW-1:0] oct_q, oct_d;
  logic              load;
  logic              fire;

  assign fire    = busy_q && out_o.ready;
  assign ready_o = !busy_q || (out_o.ready && rem_q == 4'd1);
  assign load    = valid_i && ready_o;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    bad_d  = bad_q;
    oct_d  = oct_q;
    if (load) begin
      // drop frames that carry no octet
      busy_d = data_i.cnt != 4'd0;
      rem_d  = data_i.cnt;
      bad_d  = data_i.bad;
      oct_d  = data_i.octets;
    end else if (fire) begin
      busy_d = rem_q != 4'd1;
      rem_d  = rem_q - 4'd1;
      oct_d  = {oct_q[FrameW-9:0], 8'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q <= bad_d;
    oct_q <= oct_d;
  end

  assign out_o.valid     = busy_q;
  assign out_o.out_byte  = oct_q[FrameW-1 -: 8];
  assign out_o.last      = rem_q == 4'd1;
  assign out_o.bad_range = bad_q;

endmodule

FILE: dv/aligned_per_integer_encoder_tb.sv
// Self-checking testbench for the aligned PER integer encoder.
// Depends on apie_pkg, apie_if.sv and the encoder RTL; directed table plus random integers.
module aligned_per_integer_encoder_tb;
  import apie_pkg::*;

  localparam int          RandomItems = 210;
  localparam int          LongHold    = 300;     // receiver hold-off, in cycles
  localparam int          PauseAt     = 110;     // random item before which the sender drains
  localparam int          DrainCycles = 20;      // idle wait after the last octet has been checked
  localparam int          CycleLimit  = 400000;
  localparam int          Predict     = -1;      // row has no typed expectation
  localparam int          OctW        = 8 * MaxOctets;

  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;

  // One encoded octet as it should appear on the output channel.
  typedef struct {
    logic [7:0] octet;
    logic       last;
    logic       bad;
  } per_octet_t;

  // One stimulus row; n_exp octets are typed in right-aligned, first octet highest.
  typedef struct {
    logic               act;
    logic signed [63:0] val;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    int                 n_exp;
    logic [OctW-1:0]    octets;
    logic               bad;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  apie_in_if  in_ch ();
  apie_out_if out_ch ();

  aligned_per_integer_encoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  per_octet_t per_octets_q[$];   // octets still owed by the encoder, oldest first
  stim_row_t  directed_rows[$];

  int n_accepted = 0;
  int n_octets   = 0;
  int n_errors   = 0;
  int n_unc      = 0;
  int n_con      = 0;
  int n_bad      = 0;
  int n_cycles   = 0;

  // ---------------------------------------------------------------------------
  // Expected-octet bookkeeping
  // ---------------------------------------------------------------------------
  task automatic push_octet(input logic [7:0] o, input logic last, input logic bad);
    per_octet_t e;
    e.octet = o;
    e.last  = last;
    e.bad   = bad;
    per_octets_q.push_back(e);
  endtask

  // Emit the low n octets of v, most significant first, last flag on the final one.
  task automatic push_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) push_octet(v[8*i +: 8], i == 0, 1'b0);
  endtask

  // Work out the PER octets of one integer and queue them.
  task automatic predict_per_octets(input logic act, input logic signed [63:0] val,
                                    input logic signed [63:0] lo,
                                    input logic signed [63:0] hi);
    logic [63:0] span;
    logic [63:0] offset;
    logic [63:0] t;
    logic [63:0] packed_oct;
    int          n;
    int          b;
    if (act == ACT_UNCONSTRAINED) begin
      // Smallest two's-complement width among 1, 2, 3, 4 and 8 octets.
      if (val == {{56{val[7]}}, val[7:0]}) n = 1;
      else if (val == {{48{val[15]}}, val[15:0]}) n = 2;
      else if (val == {{40{val[23]}}, val[23:0]}) n = 3;
      else if (val == {{32{val[31]}}, val[31:0]}) n = 4;
      else n = 8;
      push_octet(8'(n), 1'b0, 1'b0);
      push_be(val, n);
    end else if (hi < lo) begin
      push_octet(8'h00, 1'b1, 1'b1);
    end else begin
      span   = hi - lo;
      offset = val - lo;
      if (span != 0) begin
        if (span <= 255) begin
          // Left-justify the offset in the minimal bit count of the span.
          b = 0;
          t = span;
          while (t != 0) begin
            b++;
            t = t >> 1;
          end
          packed_oct = (offset & ((64'd1 << b) - 64'd1)) << (8 - b);
          push_octet(packed_oct[7:0], 1'b1, 1'b0);
        end else if (span <= 65535) begin
          push_be(offset, 2);
        end else begin
          if (offset < 64'd256) n = 1;
          else if (offset < 64'd65536) n = 2;
          else if (offset < 64'd16777216) n = 3;
          else n = 4;
          push_octet(8'((n - 1) << 6), 1'b0, 1'b0);
          push_be(offset, n);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_row(input logic act, input logic signed [63:0] val,
                         input logic signed [63:0] lo, input logic signed [63:0] hi,
                         input int n, input logic [OctW-1:0] oct, input logic bad);
    stim_row_t r;
    r.act    = act;
    r.val    = val;
    r.lo     = lo;
    r.hi     = hi;
    r.n_exp  = n;
    r.octets = oct;
    r.bad    = bad;
    directed_rows.push_back(r);
  endtask

  // Build one random integer. Items are unconstrained integers or well-formed bounds,
  // mostly with the value inside them, spread over every encoding form; the rest is
  // reversed bounds, out-of-range values and fully random fields.
  task automatic make_random_row(output stim_row_t r);
    int unsigned pick;
    logic [63:0] span;
    logic [63:0] offset;
    logic [63:0] a;
    logic [63:0] b;
    pick     = $urandom_range(0, 99);
    r.n_exp  = Predict;
    r.octets = '0;
    r.bad    = 1'b0;
    r.act    = ACT_CONSTRAINED;
    r.val    = rand64();
    r.lo     = rand64();
    r.hi     = rand64();
    if (pick < 35) begin
      // Unconstrained: random width of 1..8 octets, both signs; bounds are noise.
      r.act = ACT_UNCONSTRAINED;
      r.val = $signed(rand64()) >>> (8 * (8 - $urandom_range(1, 8)));
    end else if (pick < 85) begin
      if (pick < 45) span = $urandom_range(1, 255);
      else if (pick < 55) span = $urandom_range(256, 65535);
      else if (pick < 80) begin
        span = rand64() >> $urandom_range(1, 47);
        if (span < 64'd65536) span = span + 64'd65536;
      end else span = 0;
      if (span > 64'd65535) begin
        // Spread the offset over one to five octets; five tests truncation.
        offset = rand64() >> (64 - 8 * $urandom_range(1, 5));
        if (offset > span) offset = span;
      end else begin
        offset = rand64() % (span + 64'd1);
      end
      r.lo = $signed(rand64()) >>> $urandom_range(0, 63);
      if ($signed(r.lo + span) < r.lo) r.lo = -$signed(span);
      r.hi  = r.lo + span;
      r.val = ($urandom_range(0, 99) < 85) ? r.lo + offset : rand64();
    end else if (pick < 92) begin
      a = rand64();
      b = rand64();
      if (a == b) b = a ^ 64'd1;
      r.lo = ($signed(a) > $signed(b)) ? a : b;
      r.hi = ($signed(a) > $signed(b)) ? b : a;
    end else begin
      r.act = 1'($urandom_range(0, 1));
    end
  endtask

  // Offer one integer after an optional gap and hold it until it is taken.
  task automatic offer(input stim_row_t r, input bit idle_on);
    int g;
    g = pick_gap(idle_on);
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= r.act;
    in_ch.value       <= r.val;
    in_ch.lower_bound <= r.lo;
    in_ch.upper_bound <= r.hi;
    do @(posedge clk_i); while (!in_ch.ready);
    // The transaction has been taken: queue what it must produce.
    n_accepted++;
    if (r.act == ACT_UNCONSTRAINED) n_unc++;
    else if (r.hi < r.lo) n_bad++;
    else n_con++;
    if (r.n_exp == Predict) begin
      predict_per_octets(r.act, r.val, r.lo, r.hi);
    end else begin
      for (int k = 0; k < r.n_exp; k++)
        push_octet(r.octets[8*(r.n_exp-1-k) +: 8], k == r.n_exp - 1, r.bad);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if the encoder hangs.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d octets still owed",
               $time, n_cycles, per_octets_q.size());
      $display("FAIL aligned_per_integer_encoder");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls in phases, plus one long hold-off once the
  // sender is well under way so the pipeline fills and back-pressures input.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int phase_left;
    bit stalls_on;
    bit long_done;
    stall_left   = 0;
    phase_left   = 0;
    stalls_on    = 1'b1;
    long_done    = 1'b0;
    out_ch.ready = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        stalls_on  = ($urandom_range(0, 2) != 0);
        phase_left = 64;
      end
      phase_left--;
      if (!long_done && n_accepted >= 60) begin
        long_done  = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap(stalls_on);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every taken octet with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_octets
    per_octet_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_octets++;
      if (per_octets_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected octet: expected none, got %02h last %0b bad_range %0b",
                 $time, out_ch.out_byte, out_ch.last, out_ch.bad_range);
      end else begin
        want = per_octets_q.pop_front();
        if (out_ch.out_byte !== want.octet) begin
          n_errors++;
          $display("%0t: out_byte mismatch: expected %02h, got %02h",
                   $time, want.octet, out_ch.out_byte);
        end
        if (out_ch.last !== want.last) begin
          n_errors++;
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $time, want.last, out_ch.last);
        end
        if (out_ch.bad_range !== want.bad) begin
          n_errors++;
          $display("%0t: bad_range mismatch: expected %0b, got %0b",
                   $time, want.bad, out_ch.bad_range);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and run control
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t r;
    bit        idle_on;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_CONSTRAINED;
    in_ch.value       = '0;
    in_ch.lower_bound = '0;
    in_ch.upper_bound = '0;

    // Directed table: act, value, lower, upper, octet count (or Predict), octets, bad.
    // Reversed bounds, including the most extreme pair.
    add_row(ACT_CONSTRAINED, 0, 5, 4, 1, 72'h00, 1'b1);
    add_row(ACT_CONSTRAINED, 0, SMax, SMin, 1, 72'h00, 1'b1);
    // Single-value range: nothing at all.
    add_row(ACT_CONSTRAINED, -7, -7, -7, 0, 72'h0, 1'b0);
    // One-octet form at both ends of its span, and a value below the bounds.
    add_row(ACT_CONSTRAINED, 1, 0, 1, 1, 72'h80, 1'b0);
    add_row(ACT_CONSTRAINED, 12, 10, 12, Predict, 72'h0, 1'b0);
    add_row(ACT_CONSTRAINED, SMin + 255, SMin, SMin + 255, 1, 72'hFF, 1'b0);
    add_row(ACT_CONSTRAINED, 50, 100, 200, Predict, 72'h0, 1'b0);
    // Two-octet form at both ends of its span.
    add_row(ACT_CONSTRAINED, 256, 0, 256, 2, 72'h0100, 1'b0);
    add_row(ACT_CONSTRAINED, 65435, -100, 65435, 2, 72'hFFFF, 1'b0);
    // Indicator form, every length, then an offset wider than 32 bits.
    add_row(ACT_CONSTRAINED, 0, 0, 65536, 2, 72'h00_00, 1'b0);
    add_row(ACT_CONSTRAINED, 255, 0, 65536, 2, 72'h00_FF, 1'b0);
    add_row(ACT_CONSTRAINED, 256, 0, 65536, 3, 72'h40_0100, 1'b0);
    add_row(ACT_CONSTRAINED, 64536, -1000, 64'sh8000_0000, 4, 72'h80_010000, 1'b0);
    add_row(ACT_CONSTRAINED, 64'sh100_0000, 0, 64'sh100_0000_0000, 5, 72'hC0_01000000, 1'b0);
    add_row(ACT_CONSTRAINED, 64'sh12_3456_789A, 0, 64'sh100_0000_0000, 5, 72'hC0_3456789A,
            1'b0);
    // Full signed range: span does not fit in 64 signed bits.
    add_row(ACT_CONSTRAINED, SMax, SMin, SMax, 5, 72'hC0_FFFFFFFF, 1'b0);
    // Unconstrained; reversed bounds here must be ignored.
    add_row(ACT_UNCONSTRAINED, 0, 5, -5, 2, 72'h01_00, 1'b0);
    add_row(ACT_UNCONSTRAINED, -128, 0, 0, 2, 72'h01_80, 1'b0);
    add_row(ACT_UNCONSTRAINED, 127, 0, 0, 2, 72'h01_7F, 1'b0);
    add_row(ACT_UNCONSTRAINED, 128, 0, 0, 3, 72'h02_0080, 1'b0);
    add_row(ACT_UNCONSTRAINED, -32769, 0, 0, Predict, 72'h0, 1'b0);
    add_row(ACT_UNCONSTRAINED, 8388607, 0, 0, 4, 72'h03_7FFFFF, 1'b0);
    add_row(ACT_UNCONSTRAINED, -64'sd2147483648, 0, 0, 5, 72'h04_80000000, 1'b0);
    add_row(ACT_UNCONSTRAINED, 64'sd2147483648, 0, 0, 9, 72'h08_0000000080000000, 1'b0);
    add_row(ACT_UNCONSTRAINED, SMin, 0, 0, 9, 72'h08_8000000000000000, 1'b0);
    add_row(ACT_UNCONSTRAINED, SMax, 0, 0, 9, 72'h08_7FFFFFFFFFFFFFFF, 1'b0);

    // Hold reset, then release it once.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) offer(directed_rows[i], 1'b1);

    // Random part; idling is switched per block so some stretches run back to back.
    idle_on = 1'b1;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == PauseAt) begin
        // Drop valid and drain the encoder before going on.
        in_ch.valid <= 1'b0;
        do @(posedge clk_i); while (per_octets_q.size() != 0);
      end
      make_random_row(r);
      offer(r, idle_on);
    end
    in_ch.valid <= 1'b0;

    // Wait for the last octets, then give a zero-octet item time to misbehave.
    do @(posedge clk_i); while (per_octets_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Encoded %0d integers: %0d constrained, %0d unconstrained, %0d reversed ranges",
             n_accepted, n_con, n_unc, n_bad);
    $display("Checked %0d octets in %0d cycles, %0d mismatches", n_octets, n_cycles, n_errors);
    if (n_errors == 0) begin
      $display("PASS aligned_per_integer_encoder");
    end else begin
      $display("FAIL aligned_per_integer_encoder");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/apie_pkg.sv
rtl/apie_if.sv
rtl/apie_diff.sv
rtl/apie_form.sv
rtl/apie_ser.sv
rtl/aligned_per_integer_encoder.sv
dv/aligned_per_integer_encoder_tb.sv
